// File: sv/sdam_pkg.sv
// Shared constants for the speaker and wavetable audio mixer.
`timescale 1ns / 1ps

package sdam_pkg;

    // Field widths that do not follow the sample width
    localparam int GAIN_W   = 16;
    localparam int AMP_W    = 15;
    localparam int TOGGLE_W = 8;
    localparam int ADDR_W   = 4;
    localparam int DATA_W   = 32;

    // Register map: index is paddr[3:2]
    localparam logic [1:0] REG_VOLUME    = 2'd0;
    localparam logic [1:0] REG_MUTE      = 2'd1;
    localparam logic [1:0] REG_SPK_AMP   = 2'd2;
    localparam logic [1:0] REG_WAVE_GAIN = 2'd3;

    // Register reset values
    localparam logic [GAIN_W-1:0] VOLUME_RST    = 16'd32768;
    localparam logic              MUTE_RST      = 1'b0;
    localparam logic [AMP_W-1:0]  SPK_AMP_RST   = 15'd7209;
    localparam logic [GAIN_W-1:0] WAVE_GAIN_RST = 16'd31130;

    // DC blocker pole, round(0.9971 * 2^15)
    localparam logic [GAIN_W-1:0] BLOCK_COEF = 16'd32673;

endpackage

// File: sv/sdam_in_if.sv
// Input channel: one audio step (toggle count and wavetable sample).
`timescale 1ns / 1ps

interface sdam_in_if
    import sdam_pkg::*;
#(
    parameter int SAMPLE_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic [TOGGLE_W-1:0]           toggle_count;
    logic signed [SAMPLE_BITS-1:0] wave_sample;

    modport source (output valid, output toggle_count, output wave_sample, input ready);
    modport sink   (input valid, input toggle_count, input wave_sample, output ready);
endinterface

// File: sv/sdam_out_if.sv
// Output channel: one mixed audio sample.
`timescale 1ns / 1ps

interface sdam_out_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] mixed_sample;

    modport source (output valid, output mixed_sample, input ready);
    modport sink   (input valid, input mixed_sample, output ready);
endinterface

// File: sv/sdam_mul.sv
// Shared registered multiplier: signed sample times unsigned Q1.15 gain.
`timescale 1ns / 1ps

module sdam_mul
    import sdam_pkg::*;
#(
    parameter int A_W = 18
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic signed [A_W-1:0]    i_a,
    input  logic [GAIN_W-1:0]        i_b,
    output logic signed [A_W+GAIN_W:0] o_p
);
    localparam int P_W = A_W + GAIN_W + 1;

    logic signed [GAIN_W:0]  b_s;
    logic signed [P_W-1:0]   r_p;

    // Gain is unsigned: widen with a zero sign bit
    assign b_s = $signed({1'b0, i_b});

    // Capture the product when the sequencer asks for it
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= P_W'(i_a) * P_W'(b_s);
        end
    end

    assign o_p = r_p;
endmodule

// File: sv/speaker_doc_audio_mixer.sv
// Speaker plus wavetable mixer with a one-pole DC blocker and master volume.
// Usage:
//   i_sample_ch carries one step per output sample: toggle_count (odd flips
//   the speaker level) and a signed wavetable sample. o_mix_ch returns one
//   mixed sample per accepted step, in order.
//   Registers (volume, mute, speaker amplitude, wavetable gain) are written
//   over the APB port at byte address 4*index while no step is in flight.
// Sequence:
//   An accepted step passes through MIX, FILT, VOL and OUT to the result
//   register: the shared multiplier forms the wavetable product at
//   acceptance, the filter pole product next, and the volume product after
//   a filter clamp cycle. The input is ready again in the cycle after the
//   result is loaded, so a new step is not taken while one is in flight.
// Reset:
//   Synchronous, active low. Registers return to unity volume, unmuted,
//   amplitude 0.22 and gain 0.95; speaker level low and filter state zero.
// Stall:
//   The result waits in the output register; the next step is accepted and
//   computed meanwhile, and only its final load waits for the receiver.
`timescale 1ns / 1ps

module speaker_doc_audio_mixer
    import sdam_pkg::*;
#(
    parameter int SAMPLE_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    sdam_in_if.sink            i_sample_ch,
    sdam_out_if.source         o_mix_ch,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [DATA_W-1:0]  pwdata,
    output logic [DATA_W-1:0]  prdata,
    output logic               pready
);
    localparam int SB  = SAMPLE_BITS;
    localparam int YW  = SB + 2;            // filter state, Q2
    localparam int PW  = YW + GAIN_W + 1;   // product width
    localparam int RW  = PW - 15;           // rounded product width
    localparam int CW  = SB + 5;            // sum width before clamps

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MIX  = 3'd1;
    localparam logic [2:0] S_FILT = 3'd2;
    localparam logic [2:0] S_VOL  = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [2:0]             r_state, n_state;
    logic [GAIN_W-1:0]      r_volume;
    logic                   r_mute;
    logic [AMP_W-1:0]       r_spk_amp;
    logic [GAIN_W-1:0]      r_wave_gain;
    logic                   r_level;
    logic signed [SB-1:0]   r_last_in;
    logic signed [YW-1:0]   r_last_out;
    logic signed [SB-1:0]   r_x;
    logic signed [YW-1:0]   r_y;
    logic signed [SB-1:0]   r_out;
    logic                   r_out_valid;

    logic                   in_acc;
    logic                   cfg_wr;
    logic                   out_load;
    logic                   mul_en;
    logic signed [YW-1:0]   mul_a;
    logic [GAIN_W-1:0]      mul_b;
    logic signed [PW-1:0]   prod;
    logic signed [PW-1:0]   prod_rnd;
    logic signed [RW-1:0]   rnd;
    logic [AMP_W+SB-1:0]    amp_wide;
    logic signed [CW-1:0]   spk;
    logic signed [CW-1:0]   x_sum;
    logic signed [CW-1:0]   y_sum;
    logic signed [SB-1:0]   x_sat;
    logic signed [YW-1:0]   y_sat;
    logic signed [SB-1:0]   o_sat;

    assign in_acc   = i_sample_ch.valid && i_sample_ch.ready;
    assign cfg_wr   = psel && penable && pwrite;
    assign out_load = (r_state == S_OUT) && (!r_out_valid || o_mix_ch.ready);

    assign i_sample_ch.ready = (r_state == S_IDLE);
    assign o_mix_ch.valid        = r_out_valid;
    assign o_mix_ch.mixed_sample = r_out;
    assign pready = 1'b1;

    // Read back the register map
    always_comb begin
        prdata = '0;
        case (paddr[3:2])
            REG_VOLUME:    prdata = DATA_W'(r_volume);
            REG_MUTE:      prdata = DATA_W'(r_mute);
            REG_SPK_AMP:   prdata = DATA_W'(r_spk_amp);
            REG_WAVE_GAIN: prdata = DATA_W'(r_wave_gain);
            default:       prdata = '0;
        endcase
    end

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_volume    <= VOLUME_RST;
            r_mute      <= MUTE_RST;
            r_spk_amp   <= SPK_AMP_RST;
            r_wave_gain <= WAVE_GAIN_RST;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_VOLUME:    r_volume    <= pwdata[GAIN_W-1:0];
                REG_MUTE:      r_mute      <= pwdata[0];
                REG_SPK_AMP:   r_spk_amp   <= pwdata[AMP_W-1:0];
                REG_WAVE_GAIN: r_wave_gain <= pwdata[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    // Pick operands for the shared multiplier
    always_comb begin
        mul_en = 1'b0;
        mul_a  = r_y;
        mul_b  = r_mute ? '0 : r_volume;
        case (r_state)
            S_IDLE: begin
                mul_en = in_acc;
                mul_a  = YW'(i_sample_ch.wave_sample);
                mul_b  = r_wave_gain;
            end
            S_MIX: begin
                mul_en = 1'b1;
                mul_a  = r_last_out;
                mul_b  = BLOCK_COEF;
            end
            S_VOL: begin
                mul_en = 1'b1;
            end
            default: ;
        endcase
    end

    sdam_mul #(
        .A_W (YW)
    ) u_mul (
        .i_clk (i_clk),
        .i_en  (mul_en),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (prod)
    );

    // Round the product half up to the sample scale
    assign prod_rnd = prod + PW'(16384);
    assign rnd      = prod_rnd[PW-1:15];

    // Speaker square wave scaled to the sample format
    assign amp_wide = {r_spk_amp, {SB{1'b0}}};
    assign spk = r_level ? $signed(CW'(amp_wide[AMP_W+SB-1:16]))
                         : -$signed(CW'(amp_wide[AMP_W+SB-1:16]));

    assign x_sum = spk + CW'(rnd);
    assign y_sum = CW'(r_x) - CW'(r_last_in) + CW'(rnd);

    // Clamp the mix to full scale
    always_comb begin
        if (!x_sum[CW-1] && (|x_sum[CW-2:SB-1])) begin
            x_sat = {1'b0, {(SB-1){1'b1}}};
        end else if (x_sum[CW-1] && !(&x_sum[CW-2:SB-1])) begin
            x_sat = {1'b1, {(SB-1){1'b0}}};
        end else begin
            x_sat = x_sum[SB-1:0];
        end
    end

    // Saturate the filter output to the Q2 range
    always_comb begin
        if (!y_sum[CW-1] && (|y_sum[CW-2:YW-1])) begin
            y_sat = {1'b0, {(YW-1){1'b1}}};
        end else if (y_sum[CW-1] && !(&y_sum[CW-2:YW-1])) begin
            y_sat = {1'b1, {(YW-1){1'b0}}};
        end else begin
            y_sat = y_sum[YW-1:0];
        end
    end

    // Clamp the volume-scaled output to full scale
    always_comb begin
        if (!rnd[RW-1] && (|rnd[RW-2:SB-1])) begin
            o_sat = {1'b0, {(SB-1){1'b1}}};
        end else if (rnd[RW-1] && !(&rnd[RW-2:SB-1])) begin
            o_sat = {1'b1, {(SB-1){1'b0}}};
        end else begin
            o_sat = rnd[SB-1:0];
        end
    end

    // Advance the sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (in_acc) n_state = S_MIX;
            S_MIX:   n_state = S_FILT;
            S_FILT:  n_state = S_VOL;
            S_VOL:   n_state = S_OUT;
            S_OUT:   if (out_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Hold control state and filter memory
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_level     <= 1'b0;
            r_last_in   <= '0;
            r_last_out  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (in_acc && i_sample_ch.toggle_count[0]) begin
                r_level <= ~r_level;
            end
            if (r_state == S_FILT) begin
                r_last_in  <= r_x;
                r_last_out <= y_sat;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_mix_ch.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Capture intermediate values and the result
    always_ff @(posedge i_clk) begin
        if (r_state == S_MIX) begin
            r_x <= x_sat;
        end
        if (r_state == S_FILT) begin
            r_y <= y_sat;
        end
        if (out_load) begin
            r_out <= o_sat;
        end
    end
endmodule

// File: bench/speaker_doc_audio_mixer_tb.sv
// Self-checking bench for the speaker and wavetable mixer with DC blocker and volume.
`timescale 1ns / 1ps

module speaker_doc_audio_mixer_tb;
    import sdam_pkg::*;

    localparam int     SB          = 16;
    localparam longint S_MAX       = (longint'(1) << (SB - 1)) - 1;
    localparam longint S_MIN       = -(longint'(1) << (SB - 1));
    localparam longint Y_MAX       = (longint'(1) << (SB + 1)) - 1;
    localparam longint Y_MIN       = -(longint'(1) << (SB + 1));
    localparam int     HOLD_AT     = 200;
    localparam int     HOLD_CYCLES = 200;
    localparam int     DRAIN_WAIT  = 20;
    localparam int     CYCLE_LIMIT = 200000;

    typedef struct {
        logic [TOGGLE_W-1:0]  toggles;
        logic signed [SB-1:0] wave;
        int unsigned          gap;
    } t_mixer_step;

    logic i_clk = 1'b0;
    logic i_rst_n;

    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    sdam_in_if  #(.SAMPLE_BITS(SB)) step_ch ();
    sdam_out_if #(.SAMPLE_BITS(SB)) mix_ch ();

    speaker_doc_audio_mixer #(.SAMPLE_BITS(SB)) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_sample_ch (step_ch),
        .o_mix_ch    (mix_ch),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // Register copies, written only while the mixer is idle
    logic [GAIN_W-1:0] cfg_volume    = VOLUME_RST;
    logic              cfg_mute      = MUTE_RST;
    logic [AMP_W-1:0]  cfg_spk_amp   = SPK_AMP_RST;
    logic [GAIN_W-1:0] cfg_wave_gain = WAVE_GAIN_RST;

    // Predicted mixer state
    logic   spk_level   = 1'b0;
    longint blk_x_prev  = 0;
    longint blk_y_prev  = 0;

    t_mixer_step          pending_step_q[$];
    logic signed [SB-1:0] expected_mix_q[$];

    logic [2:0]           step_gap;
    logic [2:0]           out_wait;
    int                   accepted_steps;
    int                   hold_left;
    logic                 hold_done;
    logic                 quiet_phase = 1'b0;
    int                   mismatch_count = 0;
    int                   cycle_count = 0;
    logic signed [SB-1:0] last_wave = '0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic longint sat_range(input longint v, input longint lo, input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // Q1.15 product rounded half up
    function automatic longint round_q15(input longint p);
        return (p + 64'sd16384) >>> 15;
    endfunction

    // Advance the speaker level and filter state by one item, return the mixed sample
    function automatic logic signed [SB-1:0] mix_predict(input logic [TOGGLE_W-1:0] toggles,
                                                         input logic signed [SB-1:0] wave);
        longint amp;
        longint spk;
        longint wv;
        longint x;
        longint y;
        longint g;
        if (toggles[0])
            spk_level = ~spk_level;
        amp = longint'(cfg_spk_amp);
        spk = spk_level ? amp : -amp;
        wv  = round_q15(longint'(wave) * longint'(cfg_wave_gain));
        x   = sat_range(spk + wv, S_MIN, S_MAX);
        y   = x - blk_x_prev + round_q15(blk_y_prev * longint'(BLOCK_COEF));
        y   = sat_range(y, Y_MIN, Y_MAX);
        blk_x_prev = x;
        blk_y_prev = y;
        g = cfg_mute ? 0 : longint'(cfg_volume);
        return SB'(sat_range(round_q15(y * g), S_MIN, S_MAX));
    endfunction

    // Drive items from the pending queue, idling the drawn gap after each one
    always @(posedge i_clk) begin : drive_steps
        t_mixer_step nxt;
        if (!i_rst_n) begin
            step_ch.valid <= 1'b0;
            step_gap      <= '0;
            accepted_steps <= 0;
        end else begin
            if (step_ch.valid && step_ch.ready) begin
                expected_mix_q.push_back(mix_predict(step_ch.toggle_count, step_ch.wave_sample));
                accepted_steps <= accepted_steps + 1;
            end
            if (!step_ch.valid || step_ch.ready) begin
                if (step_gap != 0) begin
                    step_ch.valid <= 1'b0;
                    step_gap      <= step_gap - 3'd1;
                end else if (pending_step_q.size() != 0) begin
                    nxt = pending_step_q.pop_front();
                    step_ch.valid        <= 1'b1;
                    step_ch.toggle_count <= nxt.toggles;
                    step_ch.wave_sample  <= nxt.wave;
                    step_gap             <= 3'(nxt.gap);
                end else begin
                    step_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Check each mixed sample and draw the stall before taking the next one
    always @(posedge i_clk) begin : check_mix
        int unsigned stall;
        if (!i_rst_n) begin
            mix_ch.ready <= 1'b0;
            out_wait     <= '0;
        end else if (mix_ch.valid && mix_ch.ready) begin
            if (expected_mix_q.size() == 0) begin
                $display("%0t: mixed_sample %0d arrived with nothing expected",
                         $time, mix_ch.mixed_sample);
                mismatch_count++;
            end else if (mix_ch.mixed_sample !== expected_mix_q[0]) begin
                $display("%0t: mixed_sample expected %0d, got %0d",
                         $time, expected_mix_q[0], mix_ch.mixed_sample);
                mismatch_count++;
                void'(expected_mix_q.pop_front());
            end else begin
                void'(expected_mix_q.pop_front());
            end
            stall = quiet_phase ? 0 : $urandom_range(0, 5);
            out_wait     <= (stall == 0) ? 3'd0 : 3'(stall - 1);
            mix_ch.ready <= (stall == 0) && (hold_left == 0);
        end else if (out_wait != 0) begin
            out_wait     <= out_wait - 3'd1;
            mix_ch.ready <= 1'b0;
        end else begin
            mix_ch.ready <= (hold_left == 0);
        end
    end

    // Hold the receiver off once for a long stretch so the input backs up
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (!hold_done && accepted_steps >= HOLD_AT) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    // Stop a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("speaker_doc_audio_mixer: mismatch");
            $finish;
        end
    end

    task automatic push_step(input logic [TOGGLE_W-1:0] toggles, input logic signed [SB-1:0] wave);
        t_mixer_step st;
        st.toggles = toggles;
        st.wave    = wave;
        st.gap     = quiet_phase ? 0 : $urandom_range(0, 5);
        pending_step_q.push_back(st);
    endtask

    // Queue random items, full-scale and repeated samples mixed in
    task automatic fill_random(input int count);
        logic [TOGGLE_W-1:0]  toggles;
        logic signed [SB-1:0] wave;
        for (int k = 0; k < count; k++) begin
            toggles = ($urandom_range(0, 1) != 0) ? TOGGLE_W'($urandom_range(0, 255))
                                                  : TOGGLE_W'($urandom_range(0, 3));
            case ($urandom_range(0, 9))
                0:       wave = 16'sh7FFF;
                1:       wave = 16'sh8000;
                2:       wave = '0;
                3, 4:    wave = last_wave;
                default: wave = SB'($urandom());
            endcase
            last_wave = wave;
            push_step(toggles, wave);
        end
    endtask

    // Wait until every queued item has come back
    task automatic wait_drained();
        while (pending_step_q.size() != 0 || step_ch.valid || expected_mix_q.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic apb_write(input logic [1:0] reg_idx, input logic [DATA_W-1:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (reg_idx)
            REG_VOLUME:    cfg_volume    = value[GAIN_W-1:0];
            REG_MUTE:      cfg_mute      = value[0];
            REG_SPK_AMP:   cfg_spk_amp   = value[AMP_W-1:0];
            REG_WAVE_GAIN: cfg_wave_gain = value[GAIN_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_mixer(input int unsigned vol, input int unsigned mute_on,
                             input int unsigned amp, input int unsigned gain);
        apb_write(REG_VOLUME, DATA_W'(vol));
        apb_write(REG_MUTE, DATA_W'(mute_on));
        apb_write(REG_SPK_AMP, DATA_W'(amp));
        apb_write(REG_WAVE_GAIN, DATA_W'(gain));
    endtask

    initial begin
        i_rst_n              = 1'b0;
        psel                 = 1'b0;
        penable              = 1'b0;
        pwrite               = 1'b0;
        paddr                = '0;
        pwdata               = '0;
        step_ch.valid        = 1'b0;
        step_ch.toggle_count = '0;
        step_ch.wave_sample  = '0;
        mix_ch.ready         = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset settings: zero and even counts hold the level, odd counts flip it
        push_step(8'd0, 16'sd0);
        push_step(8'd2, 16'sd0);
        push_step(8'd1, 16'sh7FFF);
        push_step(8'd255, 16'sh8000);
        // Full-scale swings every item drive the mix into saturation
        for (int k = 0; k < 8; k++)
            push_step(TOGGLE_W'(1 + 2 * k), k[0] ? 16'sh8000 : 16'sh7FFF);
        // Hold the input still and let the blocker decay, then patterned toggles and samples
        push_step(8'd0, 16'sd0);
        push_step(8'd254, 16'sd0);
        push_step(8'd128, 16'sd0);
        push_step(8'd0, 16'sd0);
        push_step(8'h55, 16'sh5555);
        push_step(8'hAA, 16'shAAAA);
        push_step(8'hFE, -16'sd1);
        push_step(8'h7F, 16'sd1);
        wait_drained();

        // Gains above unity and the largest amplitude
        set_mixer(16'hFFFF, 0, 15'h7FFF, 16'hFFFF);
        fill_random(70);
        wait_drained();

        // Everything at zero
        set_mixer(0, 0, 0, 0);
        fill_random(40);
        wait_drained();

        // Muted output with random levels
        set_mixer(32768, 1, $urandom_range(0, 32767), $urandom_range(0, 32768));
        fill_random(40);
        wait_drained();

        // Back to back, no idling on either side; the long hold lands here
        quiet_phase = 1'b1;
        set_mixer(32768, 0, 32767, 32768);
        fill_random(70);
        wait_drained();
        quiet_phase = 1'b0;

        // Random settings
        for (int p = 0; p < 4; p++) begin
            set_mixer($urandom_range(0, 32768), ($urandom_range(0, 5) == 0),
                      $urandom_range(0, 32767), $urandom_range(0, 32768));
            fill_random(70);
            wait_drained();
        end

        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (mismatch_count == 0 && expected_mix_q.size() == 0) begin
            $display("speaker_doc_audio_mixer: match");
        end else begin
            $display("speaker_doc_audio_mixer: mismatch");
        end
        $finish;
    end

endmodule
